[rtl/swm_pkg.sv]
package swm_pkg;

    // Width of the window_size register field and its reset value
    localparam int         CFG_W     = 7;
    localparam logic [6:0] WIN_RESET = 7'd3;

    // Register index codes, taken from paddr[2]
    localparam logic REG_WINDOW_SIZE = 1'b0;

    // Per-beat control broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // a sample beat is accepted this cycle
        logic start;  // the beat opens a new frame
    } swm_ctl_t;

endpackage

[rtl/swm_in_if.sv]
interface swm_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sample;
    logic                         frame_start;

    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

[rtl/swm_out_if.sv]
interface swm_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

[rtl/sliding_window_maximum_core.sv]
// Running maximum of the last window_size signed samples. One sample beat is
// taken per clock and its result, if any, is on the output in the next cycle;
// the input stalls only while a finished result waits in the output register
// and the sink is not ready. The work is done by a chain of MAX_WINDOW
// comparing cells: cell k holds the maximum of the last k+1 samples of the
// frame and in each accepted beat merges the new sample with its neighbor's
// value, so the maximum for a window of w samples is the new value of cell
// w-1. No result comes out until window_size samples of the current frame
// have arrived. window_size of zero acts as 1 and values above MAX_WINDOW
// act as MAX_WINDOW; a change of window_size takes effect from the next
// sample. frame_start (and the first sample after reset) begins a new frame.
// There is no clearing pass after reset.
module sliding_window_maximum_core
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    swm_in_if.sink      in_ch,
    swm_out_if.source   out_ch
);

    localparam int CNT_W = ($clog2(MAX_WINDOW + 1) > CFG_W) ? $clog2(MAX_WINDOW + 1) : CFG_W;
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CFG_W-1:0]             window_size_reg;
    logic                         primed_reg;
    logic [CNT_W-1:0]             seen_reg;
    logic [CNT_W-1:0]             seen_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [DATA_WIDTH-1:0] out_data_reg;

    logic [CNT_W-1:0]             w_ext;
    logic [CNT_W-1:0]             w_eff;
    logic [CNT_W-1:0]             seen_base;
    logic [IDX_W-1:0]             sel;
    logic                         in_fire;
    logic                         produce;
    swm_ctl_t                     ctl;

    logic signed [DATA_WIDTH-1:0] cell_next [MAX_WINDOW];
    logic signed [DATA_WIDTH-1:0] cell_q    [MAX_WINDOW];

    // Configuration port: no wait states, writes land in the access phase
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW_SIZE))
        begin
            window_size_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WINDOW_SIZE)
        begin
            prdata[CFG_W-1:0] = window_size_reg;
        end
    end

    // Clamp the window size into 1 .. MAX_WINDOW
    assign w_ext = CNT_W'(window_size_reg);

    always_comb
    begin
        priority if (w_ext == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (w_ext > CNT_W'(MAX_WINDOW))
        begin
            w_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            w_eff = w_ext;
        end
    end

    assign sel = IDX_W'(w_eff - CNT_W'(1));

    // Accept a beat whenever the output register is free or being drained
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign ctl.load  = in_fire;
    assign ctl.start = in_ch.frame_start || !primed_reg;

    // Count samples of the frame, saturating at the window size
    always_comb
    begin
        if (ctl.start)
        begin
            seen_base = '0;
        end
        else if (seen_reg > w_eff)
        begin
            seen_base = w_eff;
        end
        else
        begin
            seen_base = seen_reg;
        end
        if (seen_base < w_eff)
        begin
            seen_next = seen_base + CNT_W'(1);
        end
        else
        begin
            seen_next = seen_base;
        end
    end

    assign produce = (seen_next >= w_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            seen_reg   <= '0;
        end
        else if (in_fire)
        begin
            primed_reg <= 1'b1;
            seen_reg   <= seen_next;
        end
    end

    // Chain of max cells; cell 0 always takes the new sample
    genvar k;
    generate
        for (k = 0; k < MAX_WINDOW; k++)
        begin : g_cell
            if (k == 0)
            begin : g_head
                swm_cell #(
                    .DATA_WIDTH (DATA_WIDTH)
                ) u_cell (
                    .clk      (clk),
                    .ctl      (ctl),
                    .sample   (in_ch.sample),
                    .prev_max (in_ch.sample),
                    .max_next (cell_next[k]),
                    .max_q    (cell_q[k])
                );
            end
            else
            begin : g_body
                swm_cell #(
                    .DATA_WIDTH (DATA_WIDTH)
                ) u_cell (
                    .clk      (clk),
                    .ctl      (ctl),
                    .sample   (in_ch.sample),
                    .prev_max (cell_q[k-1]),
                    .max_next (cell_next[k]),
                    .max_q    (cell_q[k])
                );
            end
        end
    endgenerate

    // Output register: load the window maximum, drop it once the sink takes it
    always_comb
    begin
        priority if (in_fire)
        begin
            out_valid_next = produce;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && produce)
        begin
            out_data_reg <= cell_next[sel];
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.window_max = out_data_reg;

    // A frame start with a window above one sample yields no beat
    a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && ctl.start && (w_eff > CNT_W'(1)) |=> !out_valid_reg)
        else $error("result produced on frame start with wide window");

    // A one-sample window echoes the sample on the next cycle
    a_unit_window: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (w_eff == CNT_W'(1)) |=> out_valid_reg
            && (out_data_reg == $past(in_ch.sample)))
        else $error("one-sample window did not echo the sample");

    // Every accepted beat leaves a nonzero sample count
    a_seen_counts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (seen_reg != '0) && primed_reg)
        else $error("sample count not advanced");

    // A pending result that is not taken blocks the input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |-> !in_ch.ready)
        else $error("input accepted while output is blocked");

endmodule

[rtl/swm_cell.sv]
module swm_cell
    import swm_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  swm_ctl_t                     ctl,
    input  logic signed [DATA_WIDTH-1:0] sample,
    input  logic signed [DATA_WIDTH-1:0] prev_max,
    output logic signed [DATA_WIDTH-1:0] max_next,
    output logic signed [DATA_WIDTH-1:0] max_q
);

    logic signed [DATA_WIDTH-1:0] max_reg;

    // Merge the new sample with the running max handed over by the neighbor;
    // a frame start drops whatever the older frame left behind
    always_comb
    begin
        if (ctl.start || (sample > prev_max))
        begin
            max_next = sample;
        end
        else
        begin
            max_next = prev_max;
        end
    end

    // Hold the max of the last (index + 1) samples of the frame
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            max_reg <= max_next;
        end
    end

    assign max_q = max_reg;

endmodule
